@@ sv/rfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Reply frame parser package
// Shared beat types, frame codes and reset constants of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rfp_pkg;

  localparam int unsigned LimitWidth = 20;
  localparam int unsigned TickWidth  = LimitWidth + 1;

  localparam logic [LimitWidth-1:0] TimeoutLimitReset = 20'd100000;
  localparam logic [7:0]            SeqWrap           = 8'd255;
  localparam logic [2:0]            EncLastIdx        = 3'd7;

  typedef enum logic [1:0] {
    FrameIdle  = 2'd0,
    FrameSpeed = 2'd1,
    FrameDock  = 2'd2,
    FrameEnc   = 2'd3
  } frame_e;

  typedef enum logic [1:0] {
    ReplySpeed = 2'd0,
    ReplyDock  = 2'd1,
    ReplyEnc   = 2'd2
  } reply_e;

  typedef struct packed {
    logic       is_timeout;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         reply_kind;
    logic [7:0]         status_byte;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [7:0]         sequence_res;
  } out_beat_t;

endpackage

`default_nettype wire

@@ sv/rfp_in_stage.sv @@
// ----------------------------------------------------------------------------
// Reply frame parser input stage
// Registers one input beat and releases it when the parser advances.
// ----------------------------------------------------------------------------
`default_nettype none

module rfp_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rfp_pkg::in_beat_t in_data_i,
  input  wire logic              advance_i,
  output logic                   item_valid_o,
  output rfp_pkg::in_beat_t      item_o
);

  logic              valid_q;
  rfp_pkg::in_beat_t data_q;
  logic              load;

  assign in_stall_o   = valid_q && !advance_i;
  assign load         = in_valid_i && !in_stall_o;
  assign item_valid_o = valid_q && advance_i;
  assign item_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || advance_i) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/rfp_parse.sv @@
// ----------------------------------------------------------------------------
// Reply frame parser core
// Holds the frame state, timeout counter and sequence number, and forms a
// result beat when a frame completes.
// ----------------------------------------------------------------------------
`default_nettype none

module rfp_parse (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rfp_pkg::LimitWidth-1:0]   cfg_data_i,
  input  wire logic                             item_valid_i,
  input  wire rfp_pkg::in_beat_t                item_i,
  output logic                                  res_valid_o,
  output rfp_pkg::out_beat_t                    res_o
);

  logic [rfp_pkg::LimitWidth-1:0] limit_q;
  rfp_pkg::frame_e                frame_q, frame_d;
  logic [2:0]                     cnt_q, cnt_d;
  logic [rfp_pkg::TickWidth-1:0]  ticks_q, ticks_d, ticks_inc;
  logic [rfp_pkg::TickWidth-1:0]  limit_ext;
  logic [7:0]                     seq_q, seq_d, seq_next;
  logic [55:0]                    shift_q;
  logic                           shift_en;

  assign limit_ext = {1'b0, limit_q};
  assign ticks_inc = (ticks_q <= limit_ext) ? ticks_q + 1'b1 : ticks_q;
  assign seq_next  = (seq_q == rfp_pkg::SeqWrap - 8'd1) ? 8'd0 : seq_q + 8'd1;

  always_comb begin
    frame_d     = frame_q;
    cnt_d       = cnt_q;
    ticks_d     = ticks_q;
    seq_d       = seq_q;
    shift_en    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (item_valid_i) begin
      if (item_i.is_timeout) begin
        ticks_d = ticks_inc;
        if (ticks_inc > limit_ext) begin
          frame_d = rfp_pkg::FrameIdle;
          cnt_d   = '0;
        end
      end else begin
        ticks_d = '0;
        case (frame_q)
          rfp_pkg::FrameIdle: begin
            if (item_i.rx_byte inside {[8'd1:8'd3]}) begin
              frame_d = rfp_pkg::frame_e'(item_i.rx_byte[1:0]);
              cnt_d   = '0;
            end
          end
          rfp_pkg::FrameSpeed, rfp_pkg::FrameDock: begin
            res_valid_o        = 1'b1;
            res_o.reply_kind   = (frame_q == rfp_pkg::FrameSpeed) ?
                                 rfp_pkg::ReplySpeed : rfp_pkg::ReplyDock;
            res_o.status_byte  = item_i.rx_byte;
            res_o.sequence_res = seq_next;
            seq_d              = seq_next;
            frame_d            = rfp_pkg::FrameIdle;
            cnt_d              = '0;
          end
          rfp_pkg::FrameEnc: begin
            shift_en = 1'b1;
            cnt_d    = cnt_q + 3'd1;
            if (cnt_q == rfp_pkg::EncLastIdx) begin
              res_valid_o        = 1'b1;
              res_o.reply_kind   = rfp_pkg::ReplyEnc;
              res_o.left_count   = shift_q[55:24];
              res_o.right_count  = {shift_q[23:0], item_i.rx_byte};
              res_o.sequence_res = seq_next;
              seq_d              = seq_next;
              frame_d            = rfp_pkg::FrameIdle;
              cnt_d              = '0;
            end
          end
          default: begin
            frame_d = rfp_pkg::FrameIdle;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= rfp_pkg::TimeoutLimitReset;
      frame_q <= rfp_pkg::FrameIdle;
      cnt_q   <= '0;
      ticks_q <= '0;
      seq_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      frame_q <= frame_d;
      cnt_q   <= cnt_d;
      ticks_q <= ticks_d;
      seq_q   <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      shift_q <= {shift_q[47:0], item_i.rx_byte};
    end
  end

endmodule

`default_nettype wire

@@ sv/rfp_out_stage.sv @@
// ----------------------------------------------------------------------------
// Reply frame parser output stage
// Holds a finished result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rfp_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               res_valid_i,
  input  wire rfp_pkg::out_beat_t res_i,
  output logic                    advance_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rfp_pkg::out_beat_t      out_data_o
);

  logic               valid_q;
  rfp_pkg::out_beat_t data_q;

  assign advance_o   = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/reply_frame_parser.sv @@
// ----------------------------------------------------------------------------
// Reply frame parser
// A beat is held in the input register, passes through the parser state update
// and its result is loaded into the result register, from which it is taken.
// Throughput: one byte or timeout beat per cycle, set by the single state
// update between the input register and the result register; a result held
// by an output stall also holds the input.
// Reset: parser idle, timeout count and sequence cleared, limit 100000.
// ----------------------------------------------------------------------------
`default_nettype none

module reply_frame_parser (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rfp_pkg::LimitWidth-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire rfp_pkg::in_beat_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output rfp_pkg::out_beat_t                  out_data_o
);

  logic               advance;
  logic               item_valid;
  rfp_pkg::in_beat_t  item;
  logic               res_valid;
  rfp_pkg::out_beat_t res;

  rfp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  rfp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  rfp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ tb/reply_frame_parser_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reply frame parser testbench
// Sends byte and timeout beats to the parser with random gaps and output
// stalls. A copy of the parsing rules in the bench predicts each reply, and
// each reply that is taken is checked field by field in arrival order.
// ----------------------------------------------------------------------------

module reply_frame_parser_tb;

  localparam int CycleLimit = 500000;
  localparam logic [rfp_pkg::LimitWidth-1:0] LimitMax = '1;

  logic                           clk = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [rfp_pkg::LimitWidth-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  rfp_pkg::in_beat_t              in_data_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  rfp_pkg::out_beat_t             out_data_o;

  rfp_pkg::frame_e                cur_frame;
  logic [3:0]                     byte_cnt;
  logic [7:0]                     frame_bytes [8];
  logic [rfp_pkg::TickWidth-1:0]  tick_cnt;
  logic [7:0]                     seq_num;
  logic [rfp_pkg::LimitWidth-1:0] timeout_lim;

  rfp_pkg::out_beat_t             expected_replies [$];
  int                             mismatches = 0;
  int                             beats_sent = 0;
  int                             cycles = 0;
  int                             stall_run = 0;
  bit                             quiet = 1'b0;

  reply_frame_parser uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void drop_frame();
    cur_frame = rfp_pkg::FrameIdle;
    byte_cnt = '0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
  endfunction

  function automatic void bump_sequence();
    logic [7:0] nxt;
    nxt = seq_num + 8'd1;
    seq_num = (nxt == rfp_pkg::SeqWrap) ? 8'd0 : nxt;
  endfunction

  function automatic void parse_beat(input rfp_pkg::in_beat_t b, output bit emit,
                                     output rfp_pkg::out_beat_t r);
    emit = 1'b0;
    r = '0;
    if (b.is_timeout) begin
      if (tick_cnt <= timeout_lim) tick_cnt++;
      if (tick_cnt > timeout_lim) drop_frame();
      return;
    end
    tick_cnt = '0;
    if (cur_frame == rfp_pkg::FrameIdle) begin
      if (b.rx_byte[7:2] == '0 &&
          rfp_pkg::frame_e'(b.rx_byte[1:0]) != rfp_pkg::FrameIdle) begin
        cur_frame = rfp_pkg::frame_e'(b.rx_byte[1:0]);
        byte_cnt = '0;
      end
      return;
    end
    frame_bytes[byte_cnt[2:0]] = b.rx_byte;
    byte_cnt++;
    if ((cur_frame == rfp_pkg::FrameSpeed || cur_frame == rfp_pkg::FrameDock) &&
        byte_cnt == 4'd1) begin
      bump_sequence();
      r.reply_kind = (cur_frame == rfp_pkg::FrameSpeed) ?
                     rfp_pkg::ReplySpeed : rfp_pkg::ReplyDock;
      r.status_byte = frame_bytes[0];
      r.sequence_res = seq_num;
      emit = 1'b1;
      drop_frame();
    end else if (cur_frame == rfp_pkg::FrameEnc &&
                 byte_cnt == 4'(rfp_pkg::EncLastIdx) + 4'd1) begin
      bump_sequence();
      r.reply_kind = rfp_pkg::ReplyEnc;
      r.left_count = {frame_bytes[0], frame_bytes[1], frame_bytes[2], frame_bytes[3]};
      r.right_count = {frame_bytes[4], frame_bytes[5], frame_bytes[6], frame_bytes[7]};
      r.sequence_res = seq_num;
      emit = 1'b1;
      drop_frame();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_beat(rfp_pkg::in_beat_t b);
    int gap;
    bit emit;
    rfp_pkg::out_beat_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk); while (in_stall_o);
    parse_beat(b, emit, r);
    if (emit) expected_replies.push_back(r);
    beats_sent++;
  endtask

  task automatic send_tick();
    rfp_pkg::in_beat_t t;
    t.is_timeout = 1'b1;
    t.rx_byte = 8'($urandom);
    send_beat(t);
  endtask

  task automatic send_byte(logic [7:0] v);
    rfp_pkg::in_beat_t t;
    t.is_timeout = 1'b0;
    t.rx_byte = v;
    send_beat(t);
  endtask

  task automatic send_payload_byte(logic [7:0] v);
    int n;
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(0, (timeout_lim < 3) ? int'(timeout_lim) : 3);
      repeat (n) send_tick();
    end
    send_byte(v);
  endtask

  task automatic send_status_frame(rfp_pkg::frame_e kind, logic [7:0] status);
    send_byte(8'(kind));
    send_payload_byte(status);
  endtask

  task automatic send_enc_frame(logic [31:0] left, logic [31:0] right);
    logic [63:0] word;
    word = {left, right};
    send_byte(8'(rfp_pkg::FrameEnc));
    for (int i = 0; i < 8; i++) send_payload_byte(word[63 - 8 * i -: 8]);
  endtask

  task automatic send_broken_frame();
    rfp_pkg::frame_e kind;
    int n;
    kind = rfp_pkg::frame_e'($urandom_range(1, 3));
    send_byte(8'(kind));
    n = (kind == rfp_pkg::FrameEnc) ? $urandom_range(0, 6) : 0;
    repeat (n) send_payload_byte(8'($urandom));
    if (timeout_lim <= 8) repeat (int'(timeout_lim) + 1 + $urandom_range(0, 2)) send_tick();
  endtask

  task automatic send_tick_run();
    int n;
    n = (timeout_lim <= 8) ? int'(timeout_lim) + $urandom_range(1, 4) : $urandom_range(1, 6);
    repeat (n) send_tick();
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_timeout_limit(logic [rfp_pkg::LimitWidth-1:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk);
    cfg_we_i <= 1'b0;
    timeout_lim = v;
  endtask

  task automatic test_status_replies();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_status_frame(rfp_pkg::FrameSpeed, 8'h00);
    send_status_frame(rfp_pkg::FrameDock, 8'hFF);
  endtask

  task automatic test_encoder_counts();
    send_enc_frame(32'h8000_0000, 32'h7FFF_FFFF);
    send_enc_frame(32'hFFFF_FFFF, 32'h0000_0001);
  endtask

  task automatic test_timeout_clear();
    set_timeout_limit(20'd1);
    send_byte(8'(rfp_pkg::FrameSpeed));
    send_tick();
    send_byte(8'h5A);
    send_byte(8'(rfp_pkg::FrameDock));
    send_tick();
    send_tick();
    send_byte(8'(rfp_pkg::FrameDock));
    send_byte(8'h33);
  endtask

  task automatic test_sequence_wrap();
    set_timeout_limit(20'($urandom_range(1, 3)));
    for (int i = 0; i < 300; i++) begin
      quiet = (i >= 120 && i < 170);
      send_status_frame($urandom_range(0, 1) ? rfp_pkg::FrameSpeed : rfp_pkg::FrameDock,
                        8'($urandom));
    end
    quiet = 1'b0;
  endtask

  task automatic test_mixed_traffic();
    int budget;
    int pick;
    rfp_pkg::in_beat_t noise;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_timeout_limit('0);
        1: set_timeout_limit(LimitMax);
        2: set_timeout_limit(20'd1);
        3: set_timeout_limit(rfp_pkg::TimeoutLimitReset);
        default: set_timeout_limit($urandom_range(0, 3) == 0 ?
                                   20'($urandom) : 20'($urandom_range(2, 8)));
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      budget = beats_sent + 85;
      while (beats_sent < budget) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_status_frame($urandom_range(0, 1) ? rfp_pkg::FrameSpeed : rfp_pkg::FrameDock,
                            8'($urandom));
        end else if (pick < 70) begin
          send_enc_frame($urandom, $urandom);
        end else if (pick < 80) begin
          send_broken_frame();
        end else if (pick < 88) begin
          send_tick_run();
        end else begin
          noise = rfp_pkg::in_beat_t'(9'($urandom));
          send_beat(noise);
        end
      end
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_run > 0) begin
      out_stall_i <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      out_stall_i <= 1'b1;
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_replies
    rfp_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected reply seq", 32'(out_data_o.sequence_res), '0);
      end else begin
        want = expected_replies.pop_front();
        if (out_data_o.reply_kind !== want.reply_kind)
          report_mismatch("reply_kind", 32'(out_data_o.reply_kind), 32'(want.reply_kind));
        if (out_data_o.status_byte !== want.status_byte)
          report_mismatch("status_byte", 32'(out_data_o.status_byte), 32'(want.status_byte));
        if (out_data_o.left_count !== want.left_count)
          report_mismatch("left_count", out_data_o.left_count, want.left_count);
        if (out_data_o.right_count !== want.right_count)
          report_mismatch("right_count", out_data_o.right_count, want.right_count);
        if (out_data_o.sequence_res !== want.sequence_res)
          report_mismatch("sequence_res", 32'(out_data_o.sequence_res), 32'(want.sequence_res));
      end
    end
  end

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("[reply_frame_parser] ERROR");
    $finish;
  end

  initial begin
    timeout_lim = rfp_pkg::TimeoutLimitReset;
    drop_frame();
    tick_cnt = '0;
    seq_num = '0;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_status_replies();
    test_encoder_counts();
    test_timeout_clear();
    test_sequence_wrap();
    test_mixed_traffic();

    settle();
    if (expected_replies.size() != 0)
      report_mismatch("missing replies", 32'(expected_replies.size()), '0);
    if (mismatches == 0) begin
      $display("[reply_frame_parser] OK");
    end else begin
      $display("[reply_frame_parser] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rfp_pkg.sv
sv/rfp_in_stage.sv
sv/rfp_parse.sv
sv/rfp_out_stage.sv
sv/reply_frame_parser.sv
tb/reply_frame_parser_tb.sv
